// ===== rtl/core/table_driven_fsm_sequencer_assert.svh =====
// assertion macros for the table-driven sequencer
`ifndef TABLE_DRIVEN_FSM_SEQUENCER_ASSERT_SVH
`define TABLE_DRIVEN_FSM_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TDFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TDFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tdfs_pkg.sv =====
// shared constants and types of the table-driven sequencer
package tdfs_pkg;

    localparam int NUM_STATES   = 16;
    localparam int NUM_SENSORS  = 16;
    localparam int STATE_W      = 4;
    localparam int SENSOR_W     = 4;
    localparam int ENTRY_W      = STATE_W + SENSOR_W;
    localparam int NUM_ENTRIES  = NUM_STATES * NUM_SENSORS;
    localparam int RANK_W       = 8;
    localparam int ENTRY_DATA_W = STATE_W + RANK_W;
    localparam int CNT_W        = 5;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_DEF_TRANS = 2'd1,
        OP_DEF_STATE = 2'd2,
        OP_STOP      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_INIT = 2'd1,
        ACT_MAIN = 2'd2,
        ACT_EXIT = 2'd3
    } act_kind_t;

    localparam logic [1:0] REG_STATES_IN_USE  = 2'd0;
    localparam logic [1:0] REG_SENSORS_IN_USE = 2'd1;
    localparam logic [1:0] REG_START_STATE    = 2'd2;

endpackage

// ===== rtl/core/tdfs_if.sv =====
// handshake channels for command words and event words
interface tdfs_in_if import tdfs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] sensor_bits;
    logic [3:0]  state_index;
    logic [3:0]  sensor_index;
    logic [3:0]  target_state;
    logic        has_init;
    logic        has_main;
    logic        has_exit;
    logic        mark_exit;

    modport source (output valid, op, sensor_bits, state_index, sensor_index, target_state,
                    has_init, has_main, has_exit, mark_exit, input ready);
    modport sink (input valid, op, sensor_bits, state_index, sensor_index, target_state,
                  has_init, has_main, has_exit, mark_exit, output ready);
endinterface

interface tdfs_out_if import tdfs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [3:0] reported_state;
    logic [1:0] action_kind;
    logic [3:0] action_state;
    logic       exit_ready;
    logic       last;

    modport source (output valid, reported_state, action_kind, action_state, exit_ready,
                    last, input ready);
    modport sink (input valid, reported_state, action_kind, action_state, exit_ready,
                  last, output ready);
endinterface

// ===== rtl/core/tdfs_ram.sv =====
// generic single-write, single-read ram with registered read data
module tdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/table_driven_fsm_sequencer.sv =====
// table-driven state machine sequencer, top level
//
//  channel   dir  protocol        carries
//  in_ch     in   valid/ready     command word: tick, define transition, define state, stop
//  out_ch    out  valid/ready     event word: state, action kind, ready flag, last
//  apb       in   apb write/read  states_in_use, sensors_in_use, start_state
//
// define and stop words are handled as they are taken; a tick holds in_ch through the
// row scan of all 16 columns through the one-read-port transition ram, the two action
// flag reads and the event words, which follow, up to five, one each cycle while out_ch
// takes them.
// reset is asynchronous and needs no clearing pass: defined marks are flip-flops.
// a stall on out_ch holds the event word; in_ch is taken only between ticks.
module table_driven_fsm_sequencer import tdfs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    tdfs_in_if.sink               in_ch,
    tdfs_out_if.source            out_ch
);
    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SCAN     = 5'b00010,
        ST_FLAG_CUR = 5'b00100,
        ST_FLAG_NXT = 5'b01000,
        ST_EMIT     = 5'b10000
    } fsm_t;

    fsm_t state_reg, state_next;

    // configuration
    logic [4:0] states_cfg_reg, sensors_cfg_reg;
    logic [3:0] start_cfg_reg;
    logic [4:0] use_states, use_sensors, lim_states;
    logic [16:0] sens_mask_wide;

    // control state
    logic [STATE_W-1:0] cur_reg, rep_reg, nxt_reg;
    logic               pending_reg, stopped_reg, frozen_reg, ready_flag_reg, ready_new_reg;
    logic [4:0]         frz_states_reg;
    logic [8:0]         rank_cnt_reg;
    logic [NUM_ENTRIES-1:0] defined_reg;
    logic [3:0]         flag_mem_reg [NUM_STATES];
    logic [2:0]         cur_flags_reg;

    // scan
    logic [15:0]        active_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               rvalid_reg, rdef_reg;
    logic [SENSOR_W-1:0] rcol_reg;
    logic               have_reg;
    logic [8:0]         best_key_reg;
    logic [STATE_W-1:0] best_tgt_reg;
    logic [4:0]         mask_reg;

    // output word
    logic               out_valid_reg;
    logic [3:0]         o_rep_reg, o_state_reg;
    logic [1:0]         o_kind_reg;
    logic               o_ready_reg, o_last_reg;

    logic               in_acc, cfg_wr, out_free;
    logic [STATE_W-1:0] flag_addr, nxt_w;
    logic [3:0]         flag_rd;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_DATA_W-1:0] ram_rdata;
    logic [STATE_W-1:0] e_tgt;
    logic [RANK_W-1:0]  e_rank;
    logic               e_live, e_take;
    logic [8:0]         e_key;
    logic               moved;
    logic [4:0]         new_mask, low_bit, rest_mask;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign use_states     = (states_cfg_reg > 5'(NUM_STATES)) ? 5'(NUM_STATES) : states_cfg_reg;
    assign use_sensors    = (sensors_cfg_reg > 5'(NUM_SENSORS)) ? 5'(NUM_SENSORS)
                                                                : sensors_cfg_reg;
    assign sens_mask_wide = (17'd1 << use_sensors) - 17'd1;
    assign lim_states     = (frz_states_reg < use_states) ? frz_states_reg : use_states;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_STATES_IN_USE:  prdata = {27'd0, states_cfg_reg};
            REG_SENSORS_IN_USE: prdata = {27'd0, sensors_cfg_reg};
            REG_START_STATE:    prdata = {28'd0, start_cfg_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_cfg_reg  <= 5'd16;
            sensors_cfg_reg <= 5'd16;
            start_cfg_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_STATES_IN_USE:  states_cfg_reg  <= pwdata[4:0];
                REG_SENSORS_IN_USE: sensors_cfg_reg <= pwdata[4:0];
                REG_START_STATE:    start_cfg_reg   <= pwdata[3:0];
                default:            ;
            endcase
        end
    end

    // transition ram: target and rank per entry
    assign ram_we    = in_acc && (op_t'(in_ch.op) == OP_DEF_TRANS) && !frozen_reg
                       && !defined_reg[{in_ch.state_index, in_ch.sensor_index}];
    assign ram_waddr = {in_ch.state_index, in_ch.sensor_index};
    assign ram_raddr = {cur_reg, cnt_reg[SENSOR_W-1:0]};

    tdfs_ram #(.WIDTH(ENTRY_DATA_W), .DEPTH(NUM_ENTRIES)) u_trans_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_ch.target_state, rank_cnt_reg[RANK_W-1:0]}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign e_tgt  = ram_rdata[ENTRY_DATA_W-1:RANK_W];
    assign e_rank = ram_rdata[RANK_W-1:0];
    // entries cut by the freeze stay out through the frozen state count
    assign e_live = rdef_reg && ({1'b0, cur_reg} < use_states) && ({1'b0, e_tgt} < lim_states);
    assign e_key  = e_live ? {1'b0, e_rank} : {5'b10000, rcol_reg};
    assign e_take = rvalid_reg && active_reg[rcol_reg] && (!have_reg || e_key < best_key_reg);

    assign nxt_w = have_reg ? best_tgt_reg : cur_reg;
    assign moved = (nxt_w != cur_reg);

    always_comb
    begin
        case (state_reg)
            ST_FLAG_CUR: flag_addr = cur_reg;
            ST_FLAG_NXT: flag_addr = nxt_w;
            default:     flag_addr = in_ch.state_index;
        endcase
    end
    assign flag_rd = flag_mem_reg[flag_addr];

    // slots: init cur, main cur, exit cur, init nxt, main nxt
    assign new_mask = {moved & flag_rd[1], moved & flag_rd[0], moved & cur_flags_reg[2],
                       (pending_reg | !moved) & cur_flags_reg[1],
                       pending_reg & cur_flags_reg[0]};
    assign low_bit   = mask_reg & (~mask_reg + 5'd1);
    assign rest_mask = mask_reg & ~low_bit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_acc && op_t'(in_ch.op) == OP_TICK) state_next = ST_SCAN;
            ST_SCAN:     if (cnt_reg == 5'(NUM_SENSORS)) state_next = ST_FLAG_CUR;
            ST_FLAG_CUR: state_next = ST_FLAG_NXT;
            ST_FLAG_NXT: state_next = ST_EMIT;
            ST_EMIT:     if (out_free && rest_mask == '0) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            pending_reg    <= 1'b1;
            stopped_reg    <= 1'b1;
            frozen_reg     <= 1'b0;
            ready_flag_reg <= 1'b0;
            frz_states_reg <= 5'd16;
            rank_cnt_reg   <= '0;
            defined_reg    <= '0;
            for (int i = 0; i < NUM_STATES; i++)
            begin
                flag_mem_reg[i] <= '0;
            end
            cnt_reg        <= '0;
            rvalid_reg     <= 1'b0;
            have_reg       <= 1'b0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (op_t'(in_ch.op))
                            OP_DEF_TRANS:
                            begin
                                if (ram_we)
                                begin
                                    defined_reg[ram_waddr] <= 1'b1;
                                    rank_cnt_reg <= rank_cnt_reg + 9'd1;
                                end
                            end
                            OP_DEF_STATE:
                            begin
                                if (flag_rd[2:0] == '0)
                                begin
                                    flag_mem_reg[in_ch.state_index][2:0] <=
                                        {in_ch.has_exit, in_ch.has_main, in_ch.has_init};
                                end
                                if (in_ch.mark_exit)
                                begin
                                    flag_mem_reg[in_ch.state_index][3] <= 1'b1;
                                end
                            end
                            OP_STOP:
                            begin
                                stopped_reg <= 1'b1;
                            end
                            OP_TICK:
                            begin
                                if (!frozen_reg)
                                begin
                                    frozen_reg     <= 1'b1;
                                    frz_states_reg <= use_states;
                                end
                                if (stopped_reg)
                                begin
                                    cur_reg     <= start_cfg_reg;
                                    pending_reg <= 1'b1;
                                    stopped_reg <= 1'b0;
                                end
                                cnt_reg  <= '0;
                                have_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg    <= cnt_reg + 5'd1;
                    rvalid_reg <= (cnt_reg < 5'(NUM_SENSORS));
                    if (e_take)
                    begin
                        have_reg <= 1'b1;
                    end
                end
                ST_FLAG_CUR:
                begin
                    rvalid_reg <= 1'b0;
                end
                ST_FLAG_NXT:
                begin
                    mask_reg    <= new_mask;
                    cur_reg     <= nxt_w;
                    pending_reg <= 1'b0;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        mask_reg <= rest_mask;
                        if (rest_mask == '0)
                        begin
                            ready_flag_reg <= ready_new_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && op_t'(in_ch.op) == OP_TICK)
        begin
            active_reg <= in_ch.sensor_bits & sens_mask_wide[15:0];
        end
        if (state_reg == ST_SCAN)
        begin
            rcol_reg <= cnt_reg[SENSOR_W-1:0];
            rdef_reg <= defined_reg[ram_raddr];
            if (e_take)
            begin
                best_key_reg <= e_key;
                best_tgt_reg <= e_live ? e_tgt : cur_reg;
            end
        end
        if (state_reg == ST_FLAG_CUR)
        begin
            cur_flags_reg <= flag_rd[2:0];
            rep_reg       <= cur_reg;
        end
        if (state_reg == ST_FLAG_NXT)
        begin
            nxt_reg       <= nxt_w;
            ready_new_reg <= ready_flag_reg | (moved & flag_rd[3]);
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            o_rep_reg  <= rep_reg;
            o_last_reg <= (rest_mask == '0);
            if (low_bit[3] || low_bit[4])
            begin
                o_state_reg <= nxt_reg;
                o_ready_reg <= ready_new_reg;
            end
            else if (mask_reg == '0)
            begin
                // the lone none word carries the ready flag of any move into an exit-marked state
                o_state_reg <= rep_reg;
                o_ready_reg <= ready_new_reg;
            end
            else
            begin
                o_state_reg <= rep_reg;
                o_ready_reg <= ready_flag_reg;
            end
            if (low_bit[0] || low_bit[3])
            begin
                o_kind_reg <= ACT_INIT;
            end
            else if (low_bit[1] || low_bit[4])
            begin
                o_kind_reg <= ACT_MAIN;
            end
            else if (low_bit[2])
            begin
                o_kind_reg <= ACT_EXIT;
            end
            else
            begin
                o_kind_reg <= ACT_NONE;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.reported_state = o_rep_reg;
    assign out_ch.action_kind    = o_kind_reg;
    assign out_ch.action_state   = o_state_reg;
    assign out_ch.exit_ready     = o_ready_reg;
    assign out_ch.last           = o_last_reg;
endmodule

// ===== rtl/core/tdfs_checker.sv =====
// port-level checks on the table-driven sequencer, bound to the top level
`include "table_driven_fsm_sequencer_assert.svh"
module tdfs_checker import tdfs_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_rep,
    input logic [1:0] out_kind,
    input logic [3:0] out_state,
    input logic       out_last
);
    `TDFS_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, pready, "pready low")
    `TDFS_ASSERT_IMP(a_none_alone, clk, rst_n, out_valid && out_kind == ACT_NONE, out_last && out_state == out_rep, "none word not alone")
    `TDFS_ASSERT_NXT(a_no_word_from_define, clk, rst_n, in_valid && in_ready && in_op != OP_TICK && !out_valid, !out_valid, "word after non-tick")
    `TDFS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "word dropped")
endmodule

bind table_driven_fsm_sequencer tdfs_checker u_tdfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rep   (out_ch.reported_state),
    .out_kind  (out_ch.action_kind),
    .out_state (out_ch.action_state),
    .out_last  (out_ch.last)
);

// ===== tb/tb_table_driven_fsm_sequencer.sv =====
// testbench for the table-driven state machine sequencer: random words against a predictor
module tb_table_driven_fsm_sequencer;
    import tdfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 3000;

    typedef struct {
        op_t         op;
        logic [15:0] sensor_bits;
        logic [3:0]  state_index;
        logic [3:0]  sensor_index;
        logic [3:0]  target_state;
        logic        has_init;
        logic        has_main;
        logic        has_exit;
        logic        mark_exit;
    } cmd_t;

    typedef struct {
        logic [3:0] reported_state;
        act_kind_t  action_kind;
        logic [3:0] action_state;
        logic       exit_ready;
        logic       last;
    } event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tdfs_in_if  in_ch ();
    tdfs_out_if out_ch ();

    table_driven_fsm_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    cmd_t   pending_cmds[$];
    event_t expected_events[$];
    int     errors = 0;
    int     stall_cycles = 0;
    bit     no_idle = 1'b0;
    logic   in_fire = 1'b0;
    logic   out_fire = 1'b0;
    int     in_gap = 0;
    int     out_gap = 0;

    // predictor copy of the sequencer
    logic [3:0] seq_next [NUM_ENTRIES];
    bit         seq_defined [NUM_ENTRIES];
    int         seq_rank [NUM_ENTRIES];
    int         seq_rank_count;
    logic [2:0] seq_actions [NUM_STATES];
    bit         seq_exit_mark [NUM_STATES];
    logic [3:0] seq_state;
    bit         seq_entering, seq_stopped, seq_frozen, seq_ready;
    logic [4:0] cfg_states, cfg_sensors;
    logic [3:0] cfg_start;

    function automatic int states_used();
        return (cfg_states < NUM_STATES) ? int'(cfg_states) : NUM_STATES;
    endfunction

    function automatic int sensors_used();
        return (cfg_sensors < NUM_SENSORS) ? int'(cfg_sensors) : NUM_SENSORS;
    endfunction

    function automatic bit entry_live(int row, int col);
        int k;
        k = row * NUM_SENSORS + col;
        if (row >= states_used() || col >= sensors_used())
            return 1'b0;
        return seq_defined[k] && (int'(seq_next[k]) < states_used());
    endfunction

    function automatic void push_event(logic [3:0] rep, act_kind_t kind, logic [3:0] st);
        event_t e;
        e.reported_state = rep;
        e.action_kind    = kind;
        e.action_state   = st;
        e.exit_ready     = seq_ready;
        e.last           = 1'b0;
        expected_events.push_back(e);
    endfunction

    function automatic void fire_action(logic [3:0] rep, logic [3:0] st, int bit_no, ref int n);
        if (seq_actions[st][bit_no])
        begin
            push_event(rep, act_kind_t'(bit_no + 1), st);
            n++;
        end
    endfunction

    function automatic void advance_sequencer(cmd_t c);
        int k, j, n, best, best_key, key, nxt;
        bit have;
        logic [3:0] cur;
        logic [15:0] active;
        n = 0;
        case (c.op)
            OP_DEF_TRANS:
            begin
                k = c.state_index * NUM_SENSORS + c.sensor_index;
                if (!seq_frozen && !seq_defined[k])
                begin
                    seq_defined[k] = 1'b1;
                    seq_next[k] = c.target_state;
                    seq_rank[k] = seq_rank_count;
                    seq_rank_count = (seq_rank_count + 1) & 16'hffff;
                end
            end
            OP_DEF_STATE:
            begin
                if (seq_actions[c.state_index] == 3'b000)
                    seq_actions[c.state_index] = {c.has_exit, c.has_main, c.has_init};
                if (c.mark_exit)
                    seq_exit_mark[c.state_index] = 1'b1;
            end
            OP_STOP:
                seq_stopped = 1'b1;
            default:
            begin
                if (!seq_frozen)
                begin
                    for (k = 0; k < NUM_ENTRIES; k++)
                        if (seq_defined[k] && int'(seq_next[k]) >= states_used())
                            seq_defined[k] = 1'b0;
                    seq_frozen = 1'b1;
                end
                if (seq_stopped)
                begin
                    seq_state = cfg_start;
                    seq_entering = 1'b1;
                    seq_stopped = 1'b0;
                end
                cur = seq_state;
                active = c.sensor_bits & 16'((32'd1 << sensors_used()) - 1);
                if (active == 16'd0)
                begin
                    fire_action(cur, cur, 0, n);
                    if (seq_entering)
                        ;
                    fire_action(cur, cur, 1, n);
                    if (!seq_entering && seq_actions[cur][0])
                    begin
                        // init only fires on entry: undo the speculative one
                        void'(expected_events.pop_back());
                        n--;
                        if (seq_actions[cur][1])
                        begin
                            void'(expected_events.pop_back());
                            n--;
                            fire_action(cur, cur, 1, n);
                        end
                    end
                    seq_entering = 1'b0;
                end
                else
                begin
                    have = 1'b0;
                    best = 0;
                    best_key = 0;
                    for (j = 0; j < 16; j++)
                        if (active[j])
                        begin
                            key = entry_live(cur, j) ? seq_rank[cur * NUM_SENSORS + j]
                                                     : 32'h10000 + j;
                            if (!have || key < best_key)
                            begin
                                best = j;
                                best_key = key;
                                have = 1'b1;
                            end
                        end
                    nxt = entry_live(cur, best) ? int'(seq_next[cur * NUM_SENSORS + best])
                                                : int'(cur);
                    if (seq_entering)
                    begin
                        fire_action(cur, cur, 0, n);
                        fire_action(cur, cur, 1, n);
                        if (nxt != cur)
                            fire_action(cur, cur, 2, n);
                        seq_entering = 1'b0;
                    end
                    else if (nxt == cur)
                        fire_action(cur, cur, 1, n);
                    else
                        fire_action(cur, cur, 2, n);
                    if (nxt != cur)
                    begin
                        seq_state = 4'(nxt);
                        if (seq_exit_mark[nxt])
                            seq_ready = 1'b1;
                        fire_action(cur, 4'(nxt), 0, n);
                        fire_action(cur, 4'(nxt), 1, n);
                    end
                end
                if (n == 0)
                begin
                    push_event(cur, ACT_NONE, cur);
                    n++;
                end
                expected_events[$].last = 1'b1;
            end
        endcase
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // handshake sampling, checking and watchdog
    always @(posedge clk)
    begin
        event_t e;
        cmd_t c;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word state=%0d kind=%0d act=%0d rdy=%0b last=%0b",
                             $realtime, out_ch.reported_state, out_ch.action_kind,
                             out_ch.action_state, out_ch.exit_ready, out_ch.last);
                end
                else
                begin
                    e = expected_events.pop_front();
                    if (out_ch.reported_state !== e.reported_state || out_ch.action_kind !== e.action_kind
                        || out_ch.action_state !== e.action_state
                        || out_ch.exit_ready !== e.exit_ready || out_ch.last !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected state=%0d kind=%0d act=%0d rdy=%0b last=%0b",
                                 $realtime, e.reported_state, e.action_kind, e.action_state,
                                 e.exit_ready, e.last);
                        $display("%0t:          actual   state=%0d kind=%0d act=%0d rdy=%0b last=%0b",
                                 $realtime, out_ch.reported_state, out_ch.action_kind,
                                 out_ch.action_state, out_ch.exit_ready, out_ch.last);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                c.op           = op_t'(in_ch.op);
                c.sensor_bits  = in_ch.sensor_bits;
                c.state_index  = in_ch.state_index;
                c.sensor_index = in_ch.sensor_index;
                c.target_state = in_ch.target_state;
                c.has_init     = in_ch.has_init;
                c.has_main     = in_ch.has_main;
                c.has_exit     = in_ch.has_exit;
                c.mark_exit    = in_ch.mark_exit;
                advance_sequencer(c);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
        in_fire  <= in_ch.valid && in_ch.ready;
        out_fire <= out_ch.valid && out_ch.ready;
    end

    // command word driver
    always @(negedge clk)
    begin
        cmd_t c;
        if (rst_n && !(in_ch.valid && !in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                in_ch.op           <= c.op;
                in_ch.sensor_bits  <= c.sensor_bits;
                in_ch.state_index  <= c.state_index;
                in_ch.sensor_index <= c.sensor_index;
                in_ch.target_state <= c.target_state;
                in_ch.has_init     <= c.has_init;
                in_ch.has_main     <= c.has_main;
                in_ch.has_exit     <= c.has_exit;
                in_ch.mark_exit    <= c.mark_exit;
                in_ch.valid        <= 1'b1;
                in_gap = draw_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // event word receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                out_gap = draw_gap();
            if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    function automatic cmd_t make_cmd(op_t op, logic [15:0] bits, logic [3:0] si, logic [3:0] sj,
                                      logic [3:0] tg, logic [3:0] marks);
        cmd_t c;
        c.op           = op;
        c.sensor_bits  = bits;
        c.state_index  = si;
        c.sensor_index = sj;
        c.target_state = tg;
        {c.mark_exit, c.has_exit, c.has_main, c.has_init} = marks;
        return c;
    endfunction

    function automatic cmd_t random_cmd(op_t op);
        cmd_t c;
        c = make_cmd(op, 16'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
        if (op == OP_TICK)
            case ($urandom_range(0, 5))
                0: c.sensor_bits = 16'd0;
                1, 2: c.sensor_bits = 16'd1 << $urandom_range(0, 15);
                3: c.sensor_bits = (16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15));
                default: ;
            endcase
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [4:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'(idx) << 2;
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_STATES_IN_USE:  cfg_states = value;
            REG_SENSORS_IN_USE: cfg_sensors = value;
            default:            cfg_start = value[3:0];
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() > 0 || in_ch.valid || expected_events.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [4:0] states, logic [4:0] sensors, logic [3:0] start, int count);
        int i, r;
        write_reg(REG_STATES_IN_USE, states);
        write_reg(REG_SENSORS_IN_USE, sensors);
        write_reg(REG_START_STATE, 5'(start));
        no_idle = ($urandom_range(0, 3) == 0);
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                pending_cmds.push_back(random_cmd(OP_STOP));
            else if (r == 1)
                pending_cmds.push_back(random_cmd(OP_DEF_STATE));
            else if (r == 2)
                pending_cmds.push_back(random_cmd(OP_DEF_TRANS));
            else
                pending_cmds.push_back(random_cmd(OP_TICK));
        end
        drain();
    endtask

    initial
    begin
        int i;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_TICK;
        in_ch.sensor_bits = '0;
        in_ch.state_index = '0;
        in_ch.sensor_index = '0;
        in_ch.target_state = '0;
        in_ch.has_init = 1'b0;
        in_ch.has_main = 1'b0;
        in_ch.has_exit = 1'b0;
        in_ch.mark_exit = 1'b0;
        out_ch.ready = 1'b0;
        for (i = 0; i < NUM_ENTRIES; i++)
        begin
            seq_defined[i] = 1'b0;
            seq_next[i] = '0;
            seq_rank[i] = 0;
        end
        for (i = 0; i < NUM_STATES; i++)
        begin
            seq_actions[i] = '0;
            seq_exit_mark[i] = 1'b0;
        end
        seq_rank_count = 0;
        seq_state = '0;
        seq_entering = 1'b1;
        seq_stopped = 1'b1;
        seq_frozen = 1'b0;
        seq_ready = 1'b0;
        cfg_states = 5'd16;
        cfg_sensors = 5'd16;
        cfg_start = 4'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // table build before the first tick freezes it
        write_reg(REG_STATES_IN_USE, 5'd12);
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd0, 4'd0, 4'd1, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd0, 4'd0, 4'd5, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd0, 4'd15, 4'd15, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd0, 4'd3, 4'd0, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd1, 4'd2, 4'd11, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd15, 4'd15, 4'd0, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_STATE, '0, 4'd0, '0, '0, 4'b0111));
        pending_cmds.push_back(make_cmd(OP_DEF_STATE, '0, 4'd0, '0, '0, 4'b1000));
        pending_cmds.push_back(make_cmd(OP_DEF_STATE, '0, 4'd1, '0, '0, 4'b1111));
        pending_cmds.push_back(make_cmd(OP_DEF_STATE, '0, 4'd11, '0, '0, 4'b0101));
        for (i = 0; i < 120; i++)
            pending_cmds.push_back(random_cmd(OP_DEF_TRANS));
        for (i = 2; i < NUM_STATES; i++)
            pending_cmds.push_back(random_cmd(OP_DEF_STATE));
        // directed ticks: no sensor, all sensors, the top sensor, stop and restart
        pending_cmds.push_back(make_cmd(OP_TICK, 16'h0000, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'h0000, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'hffff, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'h8000, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(OP_DEF_TRANS, '0, 4'd2, 4'd2, 4'd2, '0));
        pending_cmds.push_back(make_cmd(OP_STOP, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'h0001, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(OP_TICK, 16'h0004, '0, '0, '0, '0));
        drain();

        run_phase(5'd12, 5'd16, 4'd0, 30);
        run_phase(5'd16, 5'd16, 4'd15, 30);
        run_phase(5'd1, 5'd1, 4'd0, 25);
        run_phase(5'd16, 5'd1, 4'd3, 25);
        run_phase(5'd5, 5'd8, 4'd7, 30);
        run_phase(5'd16, 5'd16, 4'd1, 30);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tdfs_pkg.sv
rtl/core/tdfs_if.sv
rtl/core/tdfs_ram.sv
rtl/core/table_driven_fsm_sequencer.sv
rtl/core/tdfs_checker.sv
tb/tb_table_driven_fsm_sequencer.sv
